[design/cpsm_pkg.sv]
// Shared types and constants for the charge pilot state monitor.
// Holds the pilot state encoding, register map and configuration/result structs.
// No dependencies.
`timescale 1ns / 1ps

package cpsm_pkg;

  // Pilot state codes: A..F, pilot fault, none yet
  typedef enum logic [2:0] {
    ST_A    = 3'd0,
    ST_B    = 3'd1,
    ST_C    = 3'd2,
    ST_D    = 3'd3,
    ST_E    = 3'd4,
    ST_F    = 3'd5,
    ST_PF   = 3'd6,
    ST_NONE = 3'd7
  } pilot_state_e;

  // Register map, word index taken from paddr[3:2]
  localparam logic [1:0] REG_D_LOWER  = 2'd0;
  localparam logic [1:0] REG_MAX_DIFF = 2'd1;
  localparam logic [1:0] REG_DUTY_MIN = 2'd2;
  localparam logic [1:0] REG_DUTY_MAX = 2'd3;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef struct packed {
    logic [13:0] d_lower_mv;
    logic [13:0] max_diff_mv;
    logic [9:0]  duty_min;
    logic [9:0]  duty_max;
  } cfg_t;

  typedef struct packed {
    pilot_state_e classified_state;
    pilot_state_e stable_state;
    logic         state_changed;
    logic         short_fault;
    logic         vent_fault;
    logic         diode_flag;
    logic         pilot_flag;
    logic         any_error;
  } result_t;

endpackage

[design/cpsm_regs.sv]
// APB configuration registers of the charge pilot state monitor.
// Depends on cpsm_pkg for the register map and cfg_t.
`timescale 1ns / 1ps

module cpsm_regs
  import cpsm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Write the addressed register, truncated to its width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.d_lower_mv  <= 14'd2000;
      cfg_q.max_diff_mv <= 14'd1200;
      cfg_q.duty_min    <= 10'd30;
      cfg_q.duty_max    <= 10'd970;
    end else if (wr_en) begin
      case (reg_idx)
        REG_D_LOWER:  cfg_q.d_lower_mv  <= pwdata[13:0];
        REG_MAX_DIFF: cfg_q.max_diff_mv <= pwdata[13:0];
        REG_DUTY_MIN: cfg_q.duty_min    <= pwdata[9:0];
        REG_DUTY_MAX: cfg_q.duty_max    <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Read back, zero extended
  always_comb begin
    case (reg_idx)
      REG_D_LOWER:  prdata = {18'd0, cfg_q.d_lower_mv};
      REG_MAX_DIFF: prdata = {18'd0, cfg_q.max_diff_mv};
      REG_DUTY_MIN: prdata = {22'd0, cfg_q.duty_min};
      REG_DUTY_MAX: prdata = {22'd0, cfg_q.duty_max};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[design/cpsm_core.sv]
// Classification, fault evaluation and debounce for one pilot sample.
// Holds the previous state, debounce and fault latches; depends on cpsm_pkg.
`timescale 1ns / 1ps

module cpsm_core
  import cpsm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic signed [14:0] pos_mv_i,
  input  logic signed [14:0] neg_mv_i,
  input  logic [9:0]         duty_permille_i,
  input  cfg_t               cfg_i,
  output result_t            res_o
);

  localparam logic signed [15:0] V_P13000 = 16'sd13000;
  localparam logic signed [15:0] V_P11000 = 16'sd11000;
  localparam logic signed [15:0] V_P10000 = 16'sd10000;
  localparam logic signed [15:0] V_P8000  = 16'sd8000;
  localparam logic signed [15:0] V_P7000  = 16'sd7000;
  localparam logic signed [15:0] V_P5000  = 16'sd5000;
  localparam logic signed [15:0] V_P4000  = 16'sd4000;
  localparam logic signed [15:0] V_N1000  = -16'sd1000;
  localparam logic signed [15:0] V_N2000  = -16'sd2000;
  localparam logic signed [15:0] V_N10000 = -16'sd10000;
  localparam logic signed [15:0] V_N11000 = -16'sd11000;
  localparam logic signed [15:0] V_N13000 = -16'sd13000;
  localparam logic [9:0]         DUTY_FULL = 10'd1000;

  // Threshold table with hysteresis on the previous state
  function automatic pilot_state_e classify(input logic signed [15:0] v,
                                            input pilot_state_e prev,
                                            input logic signed [15:0] dlow);
    pilot_state_e s;
    if (v > V_P13000)       s = ST_PF;
    else if (v >= V_P11000) s = ST_A;
    else if (v >= V_P10000) s = (prev == ST_A) ? ST_A : ST_B;
    else if (v >= V_P8000)  s = ST_B;
    else if (v >= V_P7000)  s = (prev == ST_A || prev == ST_B) ? ST_B : ST_C;
    else if (v >= V_P5000)  s = ST_C;
    else if (v >= V_P4000)  s = (prev <= ST_C) ? ST_C : ST_D;
    else if (v >= dlow)     s = ST_D;
    else if (v >= V_N1000)  s = ST_E;
    else if (v >= V_N2000)  s = (prev <= ST_E) ? ST_E : ST_PF;
    else if (v >= V_N10000) s = ST_PF;
    else if (v >= V_N11000) s = (prev == ST_F) ? ST_F : ST_PF;
    else if (v >= V_N13000) s = ST_F;
    else                    s = ST_PF;
    return s;
  endfunction

  pilot_state_e       prev_q, prev_d;
  pilot_state_e       deb_q, deb_d;
  logic               diode_q, diode_d;
  logic               pilot_q, pilot_d;

  logic signed [15:0] pos, neg, dlow, sum;
  logic [15:0]        mag;
  logic               small_diff, nominal, full, below_dlow;
  logic               shrt, vent, err, changed;
  pilot_state_e       raw_st, st;

  always_comb begin
    pos  = 16'(pos_mv_i);
    neg  = 16'(neg_mv_i);
    dlow = signed'({2'b00, cfg_i.d_lower_mv});
    sum  = pos + neg;
    mag  = sum[15] ? 16'(-sum) : 16'(sum);

    small_diff = mag <= {2'b00, cfg_i.max_diff_mv};
    nominal    = (duty_permille_i >= cfg_i.duty_min) && (duty_permille_i <= cfg_i.duty_max);
    full       = (duty_permille_i == '0) || (duty_permille_i == DUTY_FULL);
    below_dlow = pos < dlow;

    raw_st = classify(pos, prev_q, dlow);

    // Short forces state E
    shrt = (full && below_dlow && (neg > V_N10000)) ||
           (nominal && below_dlow && small_diff);
    st   = shrt ? ST_E : raw_st;
    err  = shrt;

    vent = (st == ST_D) && (neg <= V_N10000);
    err  = err | vent;

    // Diode latch is sticky until state A; pilot latch follows otherwise
    diode_d = diode_q;
    pilot_d = pilot_q;
    if (diode_q && st == ST_A) begin
      diode_d = 1'b0;
    end else if (!diode_q && nominal && (pos > dlow) && small_diff) begin
      diode_d = 1'b1;
      err     = 1'b1;
    end else if (diode_q) begin
      err = 1'b1;
    end else if (st == ST_PF) begin
      pilot_d = 1'b1;
      err     = 1'b1;
    end else begin
      pilot_d = 1'b0;
    end

    // Report a new state after two equal samples in a row
    changed = (prev_q == st) && (deb_q != st);
    deb_d   = changed ? st : deb_q;
    prev_d  = st;

    res_o.classified_state = st;
    res_o.stable_state     = deb_d;
    res_o.state_changed    = changed;
    res_o.short_fault      = shrt;
    res_o.vent_fault       = vent;
    res_o.diode_flag       = diode_d;
    res_o.pilot_flag       = pilot_d;
    res_o.any_error        = err;
  end

  // Advance state only when the word moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= ST_NONE;
      deb_q   <= ST_NONE;
      diode_q <= 1'b0;
      pilot_q <= 1'b0;
    end else if (adv_i) begin
      prev_q  <= prev_d;
      deb_q   <= deb_d;
      diode_q <= diode_d;
      pilot_q <= pilot_d;
    end
  end

  a_changed_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res_o.state_changed |-> res_o.stable_state == res_o.classified_state)
    else $error("state change reported with mismatched stable state");

  a_short_forces_e: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res_o.short_fault |-> res_o.classified_state == ST_E && res_o.any_error)
    else $error("short fault without state E or error");

  a_diode_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && diode_q && !res_o.diode_flag |-> res_o.classified_state == ST_A)
    else $error("diode latch cleared outside state A");

  a_deb_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(deb_q) && $stable(prev_q))
    else $error("debounce state moved without an advancing word");

endmodule

[design/charge_pilot_state_monitor_top.sv]
// The accepted sample is held in the input register, then its result word is captured in the
// result register once that register is free or being drained.
// Throughput: one word per cycle while out_ready_i is high; the classify/fault/debounce
// logic is combinational between the input register and the result register.
// Reset: asynchronous active low; clears valids, state history to none, fault latches,
// and restores the configuration register defaults. No clearing pass.
`timescale 1ns / 1ps

module charge_pilot_state_monitor_top
  import cpsm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // Sample input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [14:0] pos_mv_i,
  input  logic signed [14:0] neg_mv_i,
  input  logic [9:0]         duty_permille_i,
  // Result output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         classified_state_o,
  output logic [2:0]         stable_state_o,
  output logic               state_changed_o,
  output logic               short_fault_o,
  output logic               vent_fault_o,
  output logic               diode_flag_o,
  output logic               pilot_flag_o,
  output logic               any_error_o
);

  cfg_t               cfg;
  result_t            res_d, res_q;
  logic               in_vld_q, out_vld_q, adv;
  logic signed [14:0] pos_q, neg_q;
  logic [9:0]         duty_q;

  cpsm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Move the held word on when the result register is free or being drained
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pos_q  <= pos_mv_i;
      neg_q  <= neg_mv_i;
      duty_q <= duty_permille_i;
    end
  end

  cpsm_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .pos_mv_i        (pos_q),
    .neg_mv_i        (neg_q),
    .duty_permille_i (duty_q),
    .cfg_i           (cfg),
    .res_o           (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign classified_state_o = res_q.classified_state;
  assign stable_state_o     = res_q.stable_state;
  assign state_changed_o    = res_q.state_changed;
  assign short_fault_o      = res_q.short_fault;
  assign vent_fault_o       = res_q.vent_fault;
  assign diode_flag_o       = res_q.diode_flag;
  assign pilot_flag_o       = res_q.pilot_flag;
  assign any_error_o        = res_q.any_error;

endmodule
